@@ rtl/kphre_pkg.sv @@
`default_nettype none

package kphre_pkg;

  // Matrix geometry; the pressed map carries one bit per key in row-major order.
  localparam int unsigned ROWS     = 4;
  localparam int unsigned COLS     = 4;
  localparam int unsigned NUM_KEYS = ROWS * COLS;
  localparam int unsigned MAP_BITS = 16;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned POS_W  = 2;

  localparam logic [TIME_W-1:0] HOLD_THRESHOLD_RESET = 32'd500;

  // Per-key phase.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  // Event codes as they appear on the result port.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_HOLD    = 2'd3
  } event_e;

  // One scan result.
  typedef struct packed {
    event_e            kind;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/kphre_key.sv @@
`default_nettype none

module kphre_key
  import kphre_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              down_i,
  input  wire logic [TIME_W-1:0] now_i,
  input  wire logic [TIME_W-1:0] threshold_i,
  input  wire logic              commit_i,
  output event_e                 event_o
);

  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] elapsed;
  logic              hold_reached;

  // Elapsed time wraps modulo 2^32, so a plain subtraction is enough.
  assign elapsed      = now_i - time_q;
  assign hold_reached = (elapsed >= threshold_i);

  // Next phase and timestamp.
  always_comb begin
    phase_d = phase_q;
    time_d  = time_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (down_i) begin
          phase_d = PH_PRESS;
          time_d  = now_i;
        end
      end
      PH_PRESS: begin
        if (!down_i) begin
          phase_d = PH_RELEASE;
        end else if (hold_reached) begin
          phase_d = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (!down_i) begin
          phase_d = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        phase_d = PH_IDLE;
        time_d  = '0;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Event this key would report for the current sample.
  always_comb begin
    event_o = EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (down_i) begin
          event_o = EV_PRESS;
        end
      end
      PH_PRESS: begin
        if (!down_i) begin
          event_o = EV_RELEASE;
        end else if (hold_reached) begin
          event_o = EV_HOLD;
        end
      end
      PH_HOLD: begin
        if (!down_i) begin
          event_o = EV_RELEASE;
        end
      end
      PH_RELEASE: begin
        event_o = EV_NONE;
      end
      default: begin
        event_o = EV_NONE;
      end
    endcase
  end

  // The key only advances when the scan reaches it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      time_q  <= '0;
    end else if (commit_i) begin
      phase_q <= phase_d;
      time_q  <= time_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/kphre_pick.sv @@
`default_nettype none

module kphre_pick
  import kphre_pkg::*;
(
  input  wire logic                process_i,
  input  event_e                   event_i [NUM_KEYS],
  output logic [NUM_KEYS-1:0]      commit_o,
  output result_t                  result_o
);

  logic seen;

  // Row-major priority scan: keys up to and including the first one with an
  // event are committed, later keys keep their state.
  always_comb begin
    seen     = 1'b0;
    commit_o = '0;
    result_o = '{kind: EV_NONE, row: '0, column: '0};
    for (int unsigned i = 0; i < NUM_KEYS; i++) begin
      commit_o[i] = process_i && !seen;
      if (!seen && (event_i[i] != EV_NONE)) begin
        result_o.kind   = event_i[i];
        result_o.row    = POS_W'(i / COLS);
        result_o.column = POS_W'(i % COLS);
        seen            = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/keypad_press_hold_release_events_top.sv @@
// Keypad press/hold/release event scanner.
// The input register holds an accepted transaction; it is scanned into the result
// register and presented from there. Throughput: one transaction per cycle while
// out_ready_i does not stall; all key machines evaluate in parallel and the row-major
// priority pick sits between the input and result registers.
// Reset: asynchronous active low; all keys go idle and the hold threshold is 500.
`default_nettype none

module keypad_press_hold_release_events_top
  import kphre_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TIME_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MAP_BITS-1:0] pressed_map_i,
  input  wire logic [TIME_W-1:0] now_time_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             event_kind_o,
  output logic [POS_W-1:0]       event_row_o,
  output logic [POS_W-1:0]       event_column_o
);

  logic [TIME_W-1:0]   threshold_q;
  logic                in_valid_q;
  logic [MAP_BITS-1:0] map_q;
  logic [TIME_W-1:0]   now_q;
  logic                out_valid_q;
  result_t             result_q;

  logic                advance;
  logic                process;
  logic                in_take;
  event_e              key_event [NUM_KEYS];
  logic [NUM_KEYS-1:0] commit;
  result_t             result;

  // Handshake: the held item is scanned whenever the result register is empty or being read.
  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Hold threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= HOLD_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      map_q <= pressed_map_i;
      now_q <= now_time_i;
    end
  end

  // One machine per key; keys beyond the map always read as released.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic down;
    if (k < MAP_BITS) begin : g_mapped
      assign down = map_q[k];
    end else begin : g_unmapped
      assign down = 1'b0;
    end

    kphre_key u_key (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .down_i      (down),
      .now_i       (now_q),
      .threshold_i (threshold_q),
      .commit_i    (commit[k]),
      .event_o     (key_event[k])
    );
  end

  kphre_pick u_pick (
    .process_i (process),
    .event_i   (key_event),
    .commit_o  (commit),
    .result_o  (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = result_q.kind;
  assign event_row_o    = result_q.row;
  assign event_column_o = result_q.column;

endmodule

`default_nettype wire
